>>> hdl/lzw_encoder_12bit_defines.svh
// Assertion macros shared by the LZW encoder modules.
`ifndef LZW_ENCODER_12BIT_DEFINES_SVH
`define LZW_ENCODER_12BIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent.
`define LZWE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzwe: same-cycle check failed");
// Check that the consequent holds in the cycle after the antecedent.
`define LZWE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzwe: next-cycle check failed");
`else
`define LZWE_ASSERT_SAME(lbl, ante, cons)
`define LZWE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/lzwe_pkg.sv
// Types and constants shared by the LZW encoder modules.
`timescale 1ns / 1ps

package lzwe_pkg;

    // Width of the emitted code field
    localparam int OUT_CODE_W    = 12;
    // First code handed out to a learned pair
    localparam int FIRST_LEARNED = 256;
    // Width of the stream tag kept in each hash slot
    localparam int EPOCH_W       = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [OUT_CODE_W-1:0] code;
        logic                  last_code;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic in_ready;
        logic clear_step;
        logic probe_next;
        logic take_hit;
        logic emit_miss;
        logic emit_last;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_fire;
        logic prefix_valid;
        logic last;
        logic slot_live;
        logic key_match;
        logic out_free;
        logic clear_done;
        logic epoch_last;
    } dp_stat_t;

endpackage

>>> hdl/lzwe_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module lzwe_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/lzwe_dpath.sv
// Datapath of the LZW encoder: prefix state, hash table and output register.
`timescale 1ns / 1ps
`include "lzw_encoder_12bit_defines.svh"

module lzwe_dpath
    import lzwe_pkg::*;
#(
    parameter int CODE_BITS = 12,
    parameter int DICT_SIZE = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  ctrl_cmd_t  cmd,
    output dp_stat_t   stat
);

    // Hash table has twice the dictionary size, so a free slot always exists
    localparam int IDX_W  = $clog2(DICT_SIZE) + 1;
    localparam int TBL_D  = 2 * DICT_SIZE;
    localparam int NF_W   = $clog2(DICT_SIZE) + 1;
    localparam int KEY_W  = CODE_BITS + 8;
    localparam int SLOT_W = EPOCH_W + KEY_W + CODE_BITS;

    logic [CODE_BITS-1:0] prefix_reg;
    logic                 prefix_valid_reg;
    logic [NF_W-1:0]      next_free_reg;
    logic [EPOCH_W-1:0]   epoch_reg;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic [IDX_W-1:0]     probe_idx_reg;
    logic [IDX_W-1:0]     clr_cnt_reg;
    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    logic [IDX_W-1:0]     hash_idx;
    logic [KEY_W-1:0]     key_cur;
    logic                 dict_full;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_addr;
    logic [SLOT_W-1:0]    ram_wdata;
    logic [SLOT_W-1:0]    ram_rdata;
    logic [EPOCH_W-1:0]   rd_epoch;
    logic [KEY_W-1:0]     rd_key;
    logic [CODE_BITS-1:0] rd_code;
    logic                 in_fire;

    // Hash the current prefix with the incoming byte
    assign hash_idx = IDX_W'(prefix_reg) ^ (IDX_W'(in_data.data_byte) << (IDX_W - 8));
    assign key_cur  = {prefix_reg, byte_reg};
    assign dict_full = (next_free_reg >= NF_W'(DICT_SIZE));
    assign in_fire  = in_valid && cmd.in_ready;

    // Split the slot read back from the table
    assign rd_epoch = ram_rdata[SLOT_W-1 -: EPOCH_W];
    assign rd_key   = ram_rdata[CODE_BITS +: KEY_W];
    assign rd_code  = ram_rdata[CODE_BITS-1:0];

    // Select table access: clearing sweep or probe/insert
    assign ram_we    = cmd.clear_step || (cmd.emit_miss && !dict_full);
    assign ram_addr  = cmd.clear_step ? clr_cnt_reg : probe_idx_reg;
    assign ram_wdata = cmd.clear_step ? '0
                                      : {epoch_reg, key_cur, CODE_BITS'(next_free_reg)};

    lzwe_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TBL_D)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Hold encoder state and advance it on controller commands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            next_free_reg    <= NF_W'(FIRST_LEARNED);
            epoch_reg        <= EPOCH_W'(1);
            clr_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end

            if (in_fire && !prefix_valid_reg)
            begin
                prefix_reg       <= CODE_BITS'(in_data.data_byte);
                prefix_valid_reg <= 1'b1;
            end
            else if (cmd.take_hit)
            begin
                prefix_reg <= rd_code;
            end
            else if (cmd.emit_miss)
            begin
                prefix_reg <= CODE_BITS'(byte_reg);
                if (!dict_full)
                begin
                    next_free_reg <= next_free_reg + NF_W'(1);
                end
            end
            else if (cmd.emit_last)
            begin
                prefix_reg       <= '0;
                prefix_valid_reg <= 1'b0;
                next_free_reg    <= NF_W'(FIRST_LEARNED);
                epoch_reg        <= (epoch_reg == {EPOCH_W{1'b1}}) ? EPOCH_W'(1)
                                                                   : epoch_reg + EPOCH_W'(1);
            end

            if (cmd.emit_miss || cmd.emit_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture item fields, probe index and output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg      <= in_data.data_byte;
            last_reg      <= in_data.end_of_stream;
            probe_idx_reg <= hash_idx;
        end
        else if (cmd.probe_next)
        begin
            probe_idx_reg <= probe_idx_reg + IDX_W'(1);
        end

        if (cmd.emit_miss || cmd.emit_last)
        begin
            out_data_reg.code      <= OUT_CODE_W'(prefix_reg);
            out_data_reg.last_code <= cmd.emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        stat.in_fire      = in_fire;
        stat.prefix_valid = prefix_valid_reg;
        stat.last         = last_reg;
        stat.slot_live    = (rd_epoch == epoch_reg);
        stat.key_match    = (rd_key == key_cur);
        stat.out_free     = !out_valid_reg || out_ready;
        stat.clear_done   = &clr_cnt_reg;
        stat.epoch_last   = (epoch_reg == {EPOCH_W{1'b1}});
    end

    `LZWE_ASSERT_SAME(a_next_free_range, 1'b1, (next_free_reg >= NF_W'(FIRST_LEARNED)) && (next_free_reg <= NF_W'(DICT_SIZE)))
    `LZWE_ASSERT_SAME(a_epoch_nonzero, 1'b1, epoch_reg != '0)
    `LZWE_ASSERT_SAME(a_emit_when_free, cmd.emit_miss || cmd.emit_last, !out_valid_reg || out_ready)
    `LZWE_ASSERT_NEXT(a_emit_shows, cmd.emit_last, out_valid_reg && out_data_reg.last_code)

endmodule

>>> hdl/lzwe_ctrl.sv
// Controller of the LZW encoder: sequences accept, probe, emit and clear.
`timescale 1ns / 1ps
`include "lzw_encoder_12bit_defines.svh"

module lzwe_ctrl
    import lzwe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_COMPARE,
        S_MISS,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_fire)
                begin
                    state_next = stat.prefix_valid ? S_LOOKUP : S_FINISH;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_COMPARE;
            end
            S_COMPARE:
            begin
                if (stat.slot_live && stat.key_match)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_FINISH;
                end
                else if (stat.slot_live)
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_LOOKUP;
                end
                else
                begin
                    state_next = S_MISS;
                end
            end
            S_MISS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_miss = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!stat.last)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_last = 1'b1;
                    state_next    = stat.epoch_last ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state; start with a clearing sweep of the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LZWE_ASSERT_SAME(a_cmd_exclusive, 1'b1, $onehot0({cmd.in_ready, cmd.clear_step, cmd.probe_next, cmd.take_hit, cmd.emit_miss, cmd.emit_last}))
    `LZWE_ASSERT_NEXT(a_lookup_compare, state_reg == S_LOOKUP, state_reg == S_COMPARE)
    `LZWE_ASSERT_NEXT(a_wrap_clears, cmd.emit_last && stat.epoch_last, state_reg == S_CLEAR)

endmodule

>>> hdl/lzw_encoder_12bit.sv
// An item whose pair hits on the first probe passes accept, read, compare and finish; each
// further hash-table probe repeats read and compare; a miss adds an emit step that waits for
// a free output register. A byte is accepted only after the last one has finished, as the
// single-port hash-table RAM probe loop sets the pace. Results wait in a one-entry output
// register while the next byte is accepted. Reset: asynchronous, active low, then a clear of all
// 2*DICT_SIZE slots (8192 by default), in_ready low, repeated after every 255 completed streams.
`timescale 1ns / 1ps

module lzw_encoder_12bit
    import lzwe_pkg::*;
#(
    parameter int CODE_BITS = 12,
    parameter int DICT_SIZE = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    lzwe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    lzwe_dpath #(
        .CODE_BITS (CODE_BITS),
        .DICT_SIZE (DICT_SIZE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Take input transfers only when the controller is waiting for a byte
    assign in_ready = cmd.in_ready;

endmodule

>>> tb/lzw_encoder_12bit_tb.sv
// Self-checking testbench for the 12-bit LZW encoder, with a dictionary-based code predictor.
`timescale 1ns / 1ps

module lzw_encoder_12bit_tb;
    import lzwe_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DICT_CODES   = 4096;
    localparam int TAIL_CYCLES  = 64;
    localparam int HOLD_CYCLES  = 600;
    localparam int FREEZE_EXTRA = 300;
    localparam int N_DIR        = 21;
    localparam int MAX_PRINTED  = 100;

    // One row of the directed table; typed rows carry their own expected codes
    typedef struct packed {
        in_item_t   stim;
        logic       typed;
        logic [1:0] n_res;
        out_item_t  res0;
        out_item_t  res1;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Predictor state: pair table tagged by stream number, so a new stream starts empty
    int          pair_owner [0:(1<<20)-1];
    bit   [11:0] pair_code  [0:(1<<20)-1];
    int          next_code;
    logic [11:0] prefix;
    bit          have_prefix;
    int          stream_id;

    out_item_t expected_codes [$];
    int        err_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_req;
    bit        hold_done;
    int        hold_left;
    dir_row_t  dir_rows [0:N_DIR-1];

    lzw_encoder_12bit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Generate the 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    // Advance the predictor by one byte and return the codes it emits
    task automatic encode_byte(input in_item_t it, output int n,
                               output out_item_t r0, output out_item_t r1);
        logic [19:0] key;
        out_item_t   fin;
        n  = 0;
        r0 = '0;
        r1 = '0;
        if (!have_prefix)
        begin
            prefix      = {4'h0, it.data_byte};
            have_prefix = 1'b1;
        end
        else
        begin
            key = {prefix, it.data_byte};
            if (pair_owner[key] == stream_id)
            begin
                prefix = pair_code[key];
            end
            else
            begin
                r0.code      = prefix;
                r0.last_code = 1'b0;
                n            = 1;
                // Learn the pair until the code space is used up, then freeze
                if (next_code < DICT_CODES)
                begin
                    pair_owner[key] = stream_id;
                    pair_code[key]  = next_code[11:0];
                    next_code++;
                end
                prefix = {4'h0, it.data_byte};
            end
        end
        // Flush the prefix on the final byte and start a fresh stream
        if (it.end_of_stream)
        begin
            fin.code      = prefix;
            fin.last_code = 1'b1;
            if (n == 0)
            begin
                r0 = fin;
            end
            else
            begin
                r1 = fin;
            end
            n++;
            have_prefix = 1'b0;
            prefix      = '0;
            next_code   = FIRST_LEARNED;
            stream_id++;
        end
    endtask

    // Offer one item, with random idle cycles ahead of it, and hold it until the transfer
    task automatic drive_transfer(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eos);
        in_item_t  it;
        int        n;
        out_item_t r0;
        out_item_t r1;
        it.data_byte     = b;
        it.end_of_stream = eos;
        drive_transfer(it);
        encode_byte(it, n, r0, r1);
        if (n > 0)
        begin
            expected_codes.push_back(r0);
        end
        if (n > 1)
        begin
            expected_codes.push_back(r1);
        end
    endtask

    function automatic dir_row_t dir_row(logic [7:0] b, logic eos, logic typed,
                                         logic [1:0] n, logic [11:0] c0, logic l0,
                                         logic [11:0] c1, logic l1);
        dir_row_t r;
        r.stim.data_byte     = b;
        r.stim.end_of_stream = eos;
        r.typed              = typed;
        r.n_res              = n;
        r.res0.code          = c0;
        r.res0.last_code     = l0;
        r.res1.code          = c1;
        r.res1.last_code     = l1;
        return r;
    endfunction

    // Check each result transfer against the oldest expected code; drive the receiver side
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (out_valid === 1'b1 && out_ready)
        begin
            if (expected_codes.size() == 0)
            begin
                report_error($sformatf("unexpected code %0d last %0d",
                                       out_data.code, out_data.last_code));
            end
            else
            begin
                want = expected_codes.pop_front();
                if (out_data.code !== want.code)
                begin
                    report_error($sformatf("code %0d, expected %0d",
                                           out_data.code, want.code));
                end
                if (out_data.last_code !== want.last_code)
                begin
                    report_error($sformatf("last_code %0d, expected %0d on code %0d",
                                           out_data.last_code, want.last_code, want.code));
                end
            end
        end
        // Hold off the receiver once for a long stretch so the encoder backs up
        if (hold_req && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("lzw_encoder_12bit_tb: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        in_item_t    it;
        int          n;
        out_item_t   r0;
        out_item_t   r1;
        int          rand_items;
        int          len;
        int          style;
        int          k;
        int          extra;
        logic [7:0]  sym [0:3];
        logic [7:0]  b;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        in_data       <= '0;
        send_idle_pct = 12;
        recv_idle_pct <= 80;
        next_code     = FIRST_LEARNED;
        prefix        = '0;
        have_prefix   = 1'b0;
        stream_id     = 1;
        rand_items    = 0;
        extra         = 0;

        // Single-byte streams, a repeated byte building a chain, a fresh stream that
        // must not see old entries, alternating extremes, and a mid-range pattern
        dir_rows[0]  = dir_row(8'h00, 1'b1, 1'b1, 2'd1, 12'h000, 1'b1, 12'h000, 1'b0);
        dir_rows[1]  = dir_row(8'hFF, 1'b1, 1'b1, 2'd1, 12'h0FF, 1'b1, 12'h000, 1'b0);
        dir_rows[2]  = dir_row(8'h41, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[3]  = dir_row(8'h41, 1'b0, 1'b1, 2'd1, 12'h041, 1'b0, 12'h000, 1'b0);
        dir_rows[4]  = dir_row(8'h41, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[5]  = dir_row(8'h41, 1'b0, 1'b1, 2'd1, 12'h100, 1'b0, 12'h000, 1'b0);
        dir_rows[6]  = dir_row(8'h41, 1'b1, 1'b1, 2'd1, 12'h100, 1'b1, 12'h000, 1'b0);
        dir_rows[7]  = dir_row(8'h41, 1'b0, 1'b1, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[8]  = dir_row(8'h41, 1'b1, 1'b1, 2'd2, 12'h041, 1'b0, 12'h041, 1'b1);
        dir_rows[9]  = dir_row(8'hFF, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[10] = dir_row(8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[11] = dir_row(8'hFF, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[12] = dir_row(8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[13] = dir_row(8'hFF, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[14] = dir_row(8'h00, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[15] = dir_row(8'hFF, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[16] = dir_row(8'h00, 1'b1, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[17] = dir_row(8'h80, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[18] = dir_row(8'h7F, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[19] = dir_row(8'h80, 1'b0, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);
        dir_rows[20] = dir_row(8'h7F, 1'b1, 1'b0, 2'd0, 12'h000, 1'b0, 12'h000, 1'b0);

        // Hold reset, then release; the clearing pass shows up as in_ready low
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < N_DIR; i++)
        begin
            it = dir_rows[i].stim;
            drive_transfer(it);
            encode_byte(it, n, r0, r1);
            if (dir_rows[i].typed)
            begin
                n  = dir_rows[i].n_res;
                r0 = dir_rows[i].res0;
                r1 = dir_rows[i].res1;
            end
            if (n > 0)
            begin
                expected_codes.push_back(r0);
            end
            if (n > 1)
            begin
                expected_codes.push_back(r1);
            end
        end

        // Random streams: mostly repetitive content so pairs hit and chains grow
        while (rand_items < 500)
        begin
            if (rand_items >= 250 && send_idle_pct != 80)
            begin
                send_idle_pct = 80;
                recv_idle_pct <= 12;
            end
            k = $urandom_range(99);
            if (k < 45)
            begin
                len = 1;
            end
            else if (k < 70)
            begin
                len = $urandom_range(3, 2);
            end
            else
            begin
                len = $urandom_range(24, 4);
            end
            style = $urandom_range(99);
            k     = $urandom_range(4, 1);
            for (int s = 0; s < 4; s++)
            begin
                sym[s] = 8'($urandom_range(255));
            end
            for (int j = 0; j < len; j++)
            begin
                if (style < 55)
                begin
                    b = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                 : sym[$urandom_range(k - 1)];
                end
                else if (style < 80)
                begin
                    b = sym[j % k];
                end
                else
                begin
                    b = 8'($urandom_range(255));
                end
                send_byte(b, (j == len - 1));
                rand_items++;
            end
        end

        // Short streams until the stream tag wraps and the table is cleared again
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        while (stream_id < 301)
        begin
            if ($urandom_range(1))
            begin
                send_byte(8'($urandom_range(255)), 1'b0);
            end
            send_byte(8'($urandom_range(255)), 1'b1);
        end

        // One long random stream that fills the dictionary and runs on frozen;
        // stall the receiver at its start so the input backs up
        hold_req <= 1'b1;
        while (next_code < DICT_CODES || extra < FREEZE_EXTRA)
        begin
            if (next_code >= DICT_CODES)
            begin
                extra++;
            end
            send_byte(8'($urandom_range(255)), 1'b0);
        end
        send_byte(8'($urandom_range(255)), 1'b1);
        in_valid <= 1'b0;

        // Drain, then allow a tail for any stray result
        while (expected_codes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_codes.size() != 0)
        begin
            report_error($sformatf("%0d codes never arrived", expected_codes.size()));
        end

        if (err_count == 0)
        begin
            $display("lzw_encoder_12bit_tb: clean");
        end
        else
        begin
            $display("lzw_encoder_12bit_tb: errors");
        end
        $finish;
    end

endmodule
